@@ rtl/cfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cfq_pkg
// shared types and constants for the circular fifo queue
// ----------------------------------------------------------------------------
package cfq_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int WORD_BITS  = 32;
	localparam int ADDR_W     = $clog2(SLOT_COUNT);
	localparam int COUNT_W    = 4;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [COUNT_W-1:0]   CAP_RESET = COUNT_W'(15);
	localparam logic                 REG_CAPACITY = 1'b0;
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_QUERY = 2'd0,
		MODE_PUSH  = 2'd1,
		MODE_POP   = 2'd2
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} state_t;

endpackage

@@ rtl/cfq_ram.sv @@
// ----------------------------------------------------------------------------
// cfq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module cfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/circular_fifo_queue_top.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_top
// ring buffer fifo of signed words with status report on every request
//
// channel   direction  signals
// request   in/out     start, busy, mode, element
// result    out        done, accepted, popped, front_word, rear_word,
//                      count, empty_res, full_res
// config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// a request is accepted, then the ram reads the new front word; the result
// strobe follows in the cycle after acceptance and busy is high during it, so
// no new request is taken while a result is being given
// asynchronous reset empties the queue and sets capacity to fifteen
// results cannot be stalled; ram contents need no clearing
// ----------------------------------------------------------------------------
module circular_fifo_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         mode,
	input  logic signed [cfq_pkg::WORD_BITS-1:0] element,
	output logic                               done,
	output logic                               accepted,
	output logic signed [cfq_pkg::WORD_BITS-1:0] popped,
	output logic signed [cfq_pkg::WORD_BITS-1:0] front_word,
	output logic signed [cfq_pkg::WORD_BITS-1:0] rear_word,
	output logic [cfq_pkg::COUNT_W-1:0]        count,
	output logic                               empty_res,
	output logic                               full_res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cfq_pkg::PADDR_W-1:0]        paddr,
	input  logic [cfq_pkg::PDATA_W-1:0]        pwdata,
	output logic [cfq_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);

	localparam int AW = cfq_pkg::ADDR_W;
	localparam int CW = cfq_pkg::COUNT_W;
	localparam int WB = cfq_pkg::WORD_BITS;

	cfq_pkg::state_t state_q, state_nxt;

	logic [CW-1:0] cap_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [WB-1:0] front_q, rear_q;
	logic          acc_s1, pop_rd_s1;
	logic [WB-1:0] popped_s1;

	logic [CW-1:0] cap_eff;
	logic          take, is_push, is_pop, push_ok, pop_ok, cfg_wr;
	logic [AW-1:0] head_nxt, tail_nxt;
	logic [WB-1:0] rdata;

	function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
		input logic [CW-1:0] cap);
		return (AW'(idx) >= AW'(cap)) ? '0 : idx + AW'(1);
	endfunction

	assign pready  = 1'b1;
	assign prdata  = cfq_pkg::PDATA_W'(cap_q);
	assign cfg_wr  = psel && penable && pwrite && pready
		&& (paddr[2] == cfq_pkg::REG_CAPACITY);

	assign cap_eff  = (cap_q == '0) ? CW'(1) : cap_q;
	assign take     = start && !busy;
	assign is_push  = take && (mode == cfq_pkg::MODE_PUSH);
	assign is_pop   = take && (mode == cfq_pkg::MODE_POP);
	assign push_ok  = is_push && (count_q != cap_eff);
	assign pop_ok   = is_pop && (count_q != '0);
	assign head_nxt = advance(head_q, cap_eff);
	assign tail_nxt = advance(tail_q, cap_eff);

	cfq_ram #(
		.WIDTH(WB),
		.DEPTH(cfq_pkg::SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(tail_q),
		.wdata(element),
		.re   (pop_ok),
		.raddr(head_nxt),
		.rdata(rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		busy      = 1'b0;
		done      = 1'b0;
		case (state_q)
			cfq_pkg::ST_IDLE: begin
				if (take) begin
					state_nxt = cfq_pkg::ST_RESP;
				end
			end
			cfq_pkg::ST_RESP: begin
				busy      = 1'b1;
				done      = 1'b1;
				state_nxt = cfq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = cfq_pkg::ST_IDLE;
			end
		endcase
	end

	// indices, count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= cfq_pkg::CAP_RESET;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			acc_s1    <= 1'b0;
			pop_rd_s1 <= 1'b0;
		end else if (cfg_wr) begin
			cap_q   <= pwdata[CW-1:0];
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			acc_s1    <= push_ok || pop_ok;
			pop_rd_s1 <= pop_ok;
			if (push_ok) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + CW'(1);
			end
			if (pop_ok) begin
				head_q  <= head_nxt;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// cached front and rear words
	always_ff @(posedge clk) begin
		if (take) begin
			if (is_pop) begin
				popped_s1 <= pop_ok ? front_q : cfq_pkg::WORD_MIN;
			end else begin
				popped_s1 <= '0;
			end
			if (push_ok) begin
				rear_q <= element;
				if (count_q == '0) begin
					front_q <= element;
				end
			end
		end else if (done && pop_rd_s1) begin
			front_q <= rdata;
		end
	end

	// result
	always_comb begin
		accepted   = acc_s1;
		popped     = popped_s1;
		count      = count_q;
		empty_res  = (count_q == '0);
		full_res   = (count_q == cap_eff);
		if (count_q == '0) begin
			front_word = cfq_pkg::WORD_MIN;
			rear_word  = cfq_pkg::WORD_MIN;
		end else begin
			front_word = pop_rd_s1 ? rdata : front_q;
			rear_word  = rear_q;
		end
	end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ring buffer fifo: requests go in through the
// start/busy handshake, each accepted request updates a behavioural copy of
// the queue, and every result strobe is compared field by field with the
// oldest predicted status; capacity is rewritten over apb between phases
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfq_pkg::*;

	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam int                   DRAIN_LIMIT = 1000;

	typedef struct {
		logic                        accepted;
		logic signed [WORD_BITS-1:0] popped;
		logic signed [WORD_BITS-1:0] front_word;
		logic signed [WORD_BITS-1:0] rear_word;
		logic [COUNT_W-1:0]          count;
		logic                        empty_flag;
		logic                        full_flag;
	} fifo_status_t;

	class fifo_scoreboard;
		logic [WORD_BITS-1:0] ring [SLOT_COUNT];
		logic [COUNT_W-1:0]   capacity_reg;
		int unsigned          head;
		int unsigned          tail;
		fifo_status_t         status_q[$];
		int                   errors;

		function new();
			capacity_reg = CAP_RESET;
			head = 0;
			tail = 0;
			errors = 0;
		endfunction

		function int unsigned usable_capacity();
			int unsigned c;
			c = capacity_reg;
			if (c == 0)
				c = 1;
			if (c > SLOT_COUNT - 1)
				c = SLOT_COUNT - 1;
			return c;
		endfunction

		function int unsigned next_index(int unsigned i, int unsigned cap);
			return (i >= cap) ? 0 : i + 1;
		endfunction

		function void note_capacity(logic [PDATA_W-1:0] value);
			capacity_reg = value[COUNT_W-1:0];
			head = 0;
			tail = 0;
		endfunction

		function void note_request(logic [1:0] req_mode, logic [WORD_BITS-1:0] word);
			fifo_status_t r;
			int unsigned  cap;
			int unsigned  held_n;
			int unsigned  last;
			cap = usable_capacity();
			r = '{default: '0};
			if (req_mode == MODE_PUSH) begin
				if (next_index(tail, cap) != head) begin
					ring[tail] = word;
					tail = next_index(tail, cap);
					r.accepted = 1'b1;
				end
			end else if (req_mode == MODE_POP) begin
				if (head == tail) begin
					r.popped = WORD_MIN;
				end else begin
					r.popped = ring[head];
					head = next_index(head, cap);
					r.accepted = 1'b1;
				end
			end
			held_n = (tail + cap + 1 - head) % (cap + 1);
			if (held_n == 0) begin
				r.front_word = WORD_MIN;
				r.rear_word = WORD_MIN;
			end else begin
				last = (tail == 0) ? cap : tail - 1;
				r.front_word = ring[head];
				r.rear_word = ring[last];
			end
			r.count = COUNT_W'(held_n);
			r.empty_flag = (held_n == 0);
			r.full_flag = (held_n == cap);
			status_q.push_back(r);
		endfunction

		function void compare_field(string field, logic signed [WORD_BITS-1:0] want,
				logic signed [WORD_BITS-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(fifo_status_t got);
			fifo_status_t want;
			if (status_q.size() == 0) begin
				$error("result strobe with no request outstanding");
				errors++;
				return;
			end
			want = status_q.pop_front();
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("popped", want.popped, got.popped);
			compare_field("front_word", want.front_word, got.front_word);
			compare_field("rear_word", want.rear_word, got.rear_word);
			compare_field("count", want.count, got.count);
			compare_field("empty_res", want.empty_flag, got.empty_flag);
			compare_field("full_res", want.full_flag, got.full_flag);
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [1:0]                  mode = 2'b00;
	logic signed [WORD_BITS-1:0] element = '0;
	logic                        done;
	logic                        accepted;
	logic signed [WORD_BITS-1:0] popped;
	logic signed [WORD_BITS-1:0] front_word;
	logic signed [WORD_BITS-1:0] rear_word;
	logic [COUNT_W-1:0]          count;
	logic                        empty_res;
	logic                        full_res;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [PADDR_W-1:0]          paddr = '0;
	logic [PDATA_W-1:0]          pwdata = '0;
	logic [PDATA_W-1:0]          prdata;
	logic                        pready;

	fifo_scoreboard queue_model = new();

	circular_fifo_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.element(element),
		.done(done),
		.accepted(accepted),
		.popped(popped),
		.front_word(front_word),
		.rear_word(rear_word),
		.count(count),
		.empty_res(empty_res),
		.full_res(full_res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin : result_monitor
		fifo_status_t seen;
		if (arst_n === 1'b1 && done === 1'b1) begin
			seen.accepted = accepted;
			seen.popped = popped;
			seen.front_word = front_word;
			seen.rear_word = rear_word;
			seen.count = count;
			seen.empty_flag = empty_res;
			seen.full_flag = full_res;
			queue_model.check_result(seen);
		end
	end

	initial begin
		#2ms;
		$display("circular_fifo_queue_top regression: fail");
		$finish;
	end

	task automatic send_request(logic [1:0] req_mode, logic [WORD_BITS-1:0] word);
		start <= 1'b1;
		mode <= req_mode;
		element <= word;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		queue_model.note_request(req_mode, word);
	endtask

	task automatic sender_gap(int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			mode <= 2'($urandom);
			element <= $urandom;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (queue_model.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(REG_CAPACITY));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		queue_model.note_capacity(value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [WORD_BITS-1:0] pick_word();
		case ($urandom_range(15))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_mode(int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return MODE_PUSH;
		if (r < 96)
			return MODE_POP;
		if (r < 98)
			return MODE_QUERY;
		return 2'b11;
	endfunction

	initial begin : stimulus
		int idle_pcts [3];
		int segment;
		int idle_pct;
		int push_pct;
		int n_items;
		logic [PDATA_W-1:0] cap_value;

		idle_pcts = '{0, 75, 11};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity, empty then partly filled
		send_request(MODE_QUERY, 32'h1234_5678);
		send_request(MODE_POP, '0);
		send_request(MODE_PUSH, WORD_MIN);
		send_request(MODE_PUSH, WORD_MAX);
		send_request(MODE_PUSH, '0);
		send_request(MODE_PUSH, '1);
		send_request(2'b11, 32'hdead_beef);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		drain_results();

		// single slot: full refusal and empty pop
		write_capacity(32'd1);
		send_request(MODE_PUSH, 32'h5a5a_5a5a);
		send_request(MODE_PUSH, 32'd1);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		drain_results();

		// zero capacity behaves as one
		write_capacity(32'd0);
		send_request(MODE_PUSH, 32'd7);
		send_request(MODE_PUSH, 32'd8);
		send_request(MODE_QUERY, '0);
		drain_results();

		// upper data bits ignored, wrap of the ring
		write_capacity(32'hffff_fff3);
		send_request(MODE_PUSH, 32'd10);
		send_request(MODE_PUSH, 32'd11);
		send_request(MODE_PUSH, 32'd12);
		send_request(MODE_PUSH, 32'd13);
		send_request(MODE_POP, '0);
		send_request(MODE_PUSH, 32'd14);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		drain_results();

		for (segment = 0; segment < 13; segment++) begin
			case (segment)
				0: cap_value = 32'd15;
				1: cap_value = 32'd1;
				2: cap_value = 32'd0;
				3: cap_value = 32'h8000_000f;
				default: cap_value = {$urandom_range(1) ? 28'($urandom) : 28'h0, 4'($urandom)};
			endcase
			write_capacity(cap_value);
			idle_pct = idle_pcts[segment % 3];
			push_pct = $urandom_range(35, 70);
			n_items = $urandom_range(120, 180);
			repeat (n_items) begin
				send_request(pick_mode(push_pct), pick_word());
				sender_gap(idle_pct);
			end
			drain_results();
		end

		if (queue_model.errors == 0 && queue_model.pending() == 0)
			$display("circular_fifo_queue_top regression: pass");
		else
			$display("circular_fifo_queue_top regression: fail");
		$finish;
	end

endmodule
